// ===== hdl/dmwbc_pkg.sv =====
// Shared types, codes and defaults of the direct-mapped write-back cache.
`default_nettype none

package dmwbc_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;

   localparam int LINE_COUNT_DEF = 256;
   localparam int LINE_BYTES_DEF = 8;
   localparam int ADDR_BITS_DEF  = 32;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FILL  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CPU      = 2'd0,
      KIND_WB       = 2'd1,
      KIND_LINE_REQ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_LEN_ERR  = 2'd1,
      STAT_FILL_ERR = 2'd2,
      STAT_BUSY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LINE_REQ
   } state_type;

   // one action per cycle: what result to emit and which store updates go with it
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BUSY,
      ACT_LEN_ERR,
      ACT_HIT,
      ACT_WB,
      ACT_LINE_REQ,
      ACT_FILL_ERR,
      ACT_FILL
   } act_type;

   typedef struct packed {
      logic    capture;
      logic    clear;
      act_type act;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_cpu;
      logic is_fill;
      logic pending;
      logic len_err;
      logic hit;
      logic victim_dirty;
      logic fill_ok;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/dmwbc_req_if.sv =====
// Request channel: cpu accesses and memory line-fill responses.
`default_nettype none

interface dmwbc_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      opcode;
   logic [dmwbc_pkg::ADDR_W-1:0]    address;
   logic [dmwbc_pkg::LEN_W-1:0]     length;
   logic [dmwbc_pkg::DATA_W-1:0]    write_data;
   logic [dmwbc_pkg::DATA_W-1:0]    fill_data;
   logic                            fill_ok;

   modport source (
      output valid, opcode, address, length, write_data, fill_data, fill_ok,
      input  ready
   );
   modport sink (
      input  valid, opcode, address, length, write_data, fill_data, fill_ok,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/dmwbc_rsp_if.sv =====
// Response channel: cpu responses and memory requests.
`default_nettype none

interface dmwbc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [1:0]                      status;
   logic [dmwbc_pkg::DATA_W-1:0]    read_data;
   logic                            hit;
   logic [dmwbc_pkg::ADDR_W-1:0]    mem_address;
   logic [dmwbc_pkg::DATA_W-1:0]    mem_data;
   logic                            last;

   modport source (
      output valid, kind, status, read_data, hit, mem_address, mem_data, last,
      input  ready
   );
   modport sink (
      input  valid, kind, status, read_data, hit, mem_address, mem_data, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/dmwbc_ctrl.sv =====
// Cache controller state machine.
`default_nettype none

module dmwbc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dmwbc_pkg::sts_type sts,
   output dmwbc_pkg::cmd_type      cmd
);

   dmwbc_pkg::state_type state_ff;
   dmwbc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmwbc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.clear   = 1'b0;
      cmd.act     = dmwbc_pkg::ACT_NONE;
      case (state_ff)
         dmwbc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = dmwbc_pkg::ST_IDLE;
            end
         end
         dmwbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = dmwbc_pkg::ST_LOOKUP;
            end
         end
         dmwbc_pkg::ST_LOOKUP: begin
            if (sts.is_cpu) begin
               if (sts.out_free) begin
                  state_in = dmwbc_pkg::ST_IDLE;
                  if (sts.pending) begin
                     cmd.act = dmwbc_pkg::ACT_BUSY;
                  end else if (sts.len_err) begin
                     cmd.act = dmwbc_pkg::ACT_LEN_ERR;
                  end else if (sts.hit) begin
                     cmd.act = dmwbc_pkg::ACT_HIT;
                  end else if (sts.victim_dirty) begin
                     cmd.act  = dmwbc_pkg::ACT_WB;
                     state_in = dmwbc_pkg::ST_LINE_REQ;
                  end else begin
                     cmd.act = dmwbc_pkg::ACT_LINE_REQ;
                  end
               end
            end else if (sts.is_fill && sts.pending) begin
               if (sts.out_free) begin
                  state_in = dmwbc_pkg::ST_IDLE;
                  cmd.act  = sts.fill_ok ? dmwbc_pkg::ACT_FILL : dmwbc_pkg::ACT_FILL_ERR;
               end
            end else begin
               // stray fill or unused opcode: dropped
               state_in = dmwbc_pkg::ST_IDLE;
            end
         end
         dmwbc_pkg::ST_LINE_REQ: begin
            if (sts.out_free) begin
               cmd.act  = dmwbc_pkg::ACT_LINE_REQ;
               state_in = dmwbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmwbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/dmwbc_dp.sv =====
// Cache datapath: request and miss registers, tag and line stores, byte merge, response register.
`default_nettype none

module dmwbc_dp #(
   parameter int LINE_COUNT = dmwbc_pkg::LINE_COUNT_DEF,
   parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = dmwbc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dmwbc_pkg::cmd_type              cmd,
   output dmwbc_pkg::sts_type                   sts,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [dmwbc_pkg::ADDR_W-1:0]    req_address,
   input  wire logic [dmwbc_pkg::LEN_W-1:0]     req_length,
   input  wire logic [dmwbc_pkg::DATA_W-1:0]    req_write_data,
   input  wire logic [dmwbc_pkg::DATA_W-1:0]    req_fill_data,
   input  wire logic                            req_fill_ok,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_kind,
   output logic [1:0]                           rsp_status,
   output logic [dmwbc_pkg::DATA_W-1:0]         rsp_read_data,
   output logic                                 rsp_hit,
   output logic [dmwbc_pkg::ADDR_W-1:0]         rsp_mem_address,
   output logic [dmwbc_pkg::DATA_W-1:0]         rsp_mem_data,
   output logic                                 rsp_last
);

   localparam int AW       = dmwbc_pkg::ADDR_W;
   localparam int LW       = dmwbc_pkg::LEN_W;
   localparam int DW       = dmwbc_pkg::DATA_W;
   localparam int OB       = $clog2(LINE_BYTES);
   localparam int IB       = $clog2(LINE_COUNT);
   localparam int OFF_W    = (OB > 0) ? OB : 1;
   localparam int EFF_ADDR = (ADDR_BITS < AW) ? ADDR_BITS : AW;
   localparam int TAG_W    = EFF_ADDR - OB - IB;
   localparam int LINE_W   = LINE_BYTES * 8;
   localparam int META_W   = TAG_W + 2;
   localparam logic [AW-1:0] ADDR_MASK =
      (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [AW-1:0] OFF_MASK = AW'(LINE_BYTES - 1);
   localparam logic [IB-1:0] LAST_IDX = IB'(LINE_COUNT - 1);

   function automatic logic [OFF_W-1:0] f_off(input logic [AW-1:0] a);
      logic [AW-1:0] t;
      t = a & OFF_MASK;
      return t[OFF_W-1:0];
   endfunction

   function automatic logic [IB-1:0] f_idx(input logic [AW-1:0] a);
      logic [AW-1:0] t;
      t = a >> OB;
      return t[IB-1:0];
   endfunction

   function automatic logic [TAG_W-1:0] f_tag(input logic [AW-1:0] a);
      logic [AW-1:0] t;
      t = a >> (OB + IB);
      return t[TAG_W-1:0];
   endfunction

   function automatic logic [AW-1:0] f_line_addr(input logic [TAG_W-1:0] tag,
                                                 input logic [IB-1:0] idx);
      logic [AW-1:0] t;
      t = (AW'(tag) << (OB + IB)) | (AW'(idx) << OB);
      return t & ADDR_MASK;
   endfunction

   // request registers
   logic [1:0]    op_ff;
   logic [AW-1:0] addr_ff;
   logic [LW-1:0] len_ff;
   logic [DW-1:0] wdata_ff;
   logic [DW-1:0] fdata_ff;
   logic          fok_ff;

   // outstanding miss
   logic          pend_ff;
   logic          pend_in;
   logic          pwr_ff;
   logic [AW-1:0] paddr_ff;
   logic [LW-1:0] plen_ff;
   logic [DW-1:0] pwdata_ff;

   // stores: meta entry is {valid, dirty, tag}
   logic [META_W-1:0] meta_mem_ff [LINE_COUNT];
   logic [LINE_W-1:0] line_mem_ff [LINE_COUNT];
   logic [META_W-1:0] meta_rd_ff;
   logic [LINE_W-1:0] line_rd_ff;
   logic              meta_we;
   logic [IB-1:0]     meta_wa;
   logic [META_W-1:0] meta_wd;
   logic              line_we;
   logic [IB-1:0]     line_wa;
   logic [LINE_W-1:0] line_wd;
   logic [IB-1:0]     rd_idx;

   logic [IB-1:0]     clr_ff;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [1:0]    kind_ff,  kind_in;
   logic [1:0]    stat_ff,  stat_in;
   logic [DW-1:0] rdata_ff, rdata_in;
   logic          hit_ff,   hit_in;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [DW-1:0] mdata_ff, mdata_in;
   logic          last_ff,  last_in;

   logic [OFF_W-1:0] req_off;
   logic [IB-1:0]    req_idx;
   logic [TAG_W-1:0] req_tag;
   logic [OFF_W-1:0] pend_off;
   logic [IB-1:0]    pend_idx;
   logic [TAG_W-1:0] pend_tag;
   logic [4:0]       len_sum;
   logic             req_write;
   logic             meta_valid;
   logic             meta_dirty;
   logic [TAG_W-1:0] meta_tag;

   // byte merge
   logic             use_fill;
   logic [LINE_W-1:0] m_base;
   logic             m_write;
   logic [OFF_W-1:0] m_off;
   logic [LW-1:0]    m_len;
   logic [DW-1:0]    m_wdata;
   logic [DW-1:0]    m_line;
   logic [DW-1:0]    m_bmask;
   logic [DW-1:0]    m_rd;
   logic [DW-1:0]    m_new;
   logic [DW-1:0]    serve_rd;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address & ADDR_MASK;
         len_ff   <= req_length;
         wdata_ff <= req_write_data;
         fdata_ff <= req_fill_data;
         fok_ff   <= req_fill_ok;
      end
   end

   assign req_off    = f_off(addr_ff);
   assign req_idx    = f_idx(addr_ff);
   assign req_tag    = f_tag(addr_ff);
   assign pend_off   = f_off(paddr_ff);
   assign pend_idx   = f_idx(paddr_ff);
   assign pend_tag   = f_tag(paddr_ff);
   assign len_sum    = 5'(req_off) + 5'(len_ff);
   assign req_write  = (op_ff == dmwbc_pkg::OP_WRITE);
   assign meta_valid = meta_rd_ff[META_W-1];
   assign meta_dirty = meta_rd_ff[META_W-2];
   assign meta_tag   = meta_rd_ff[TAG_W-1:0];
   assign rd_idx     = f_idx(req_address);

   assign sts.clr_last     = (clr_ff == LAST_IDX);
   assign sts.is_cpu       = (op_ff == dmwbc_pkg::OP_READ) || (op_ff == dmwbc_pkg::OP_WRITE);
   assign sts.is_fill      = (op_ff == dmwbc_pkg::OP_FILL);
   assign sts.pending      = pend_ff;
   assign sts.len_err      = (len_sum > 5'(LINE_BYTES));
   assign sts.hit          = meta_valid && (meta_tag == req_tag);
   assign sts.victim_dirty = meta_valid && meta_dirty;
   assign sts.fill_ok      = fok_ff;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   // shared read/merge unit; a fill serves the parked access on the returned line
   always_comb begin
      use_fill = (cmd.act == dmwbc_pkg::ACT_FILL);
      m_base   = use_fill ? fdata_ff[LINE_W-1:0] : line_rd_ff;
      m_write  = use_fill ? pwr_ff : req_write;
      m_off    = use_fill ? pend_off : req_off;
      m_len    = use_fill ? plen_ff : len_ff;
      m_wdata  = use_fill ? pwdata_ff : wdata_ff;
      m_line   = DW'(m_base);
      m_bmask  = ~({DW{1'b1}} << {m_len, 3'b000});
      m_rd     = (m_line >> {m_off, 3'b000}) & m_bmask;
      m_new    = (m_line & ~(m_bmask << {m_off, 3'b000}))
               | ((m_wdata & m_bmask) << {m_off, 3'b000});
      serve_rd = m_write ? '0 : m_rd;
   end

   always_comb begin
      meta_we = 1'b0;
      meta_wa = req_idx;
      meta_wd = '0;
      line_we = 1'b0;
      line_wa = req_idx;
      line_wd = m_new[LINE_W-1:0];
      case (cmd.act)
         dmwbc_pkg::ACT_HIT: begin
            meta_we = req_write;
            meta_wd = {1'b1, 1'b1, req_tag};
            line_we = req_write;
         end
         dmwbc_pkg::ACT_WB: begin
            meta_we = 1'b1;
            meta_wd = {1'b1, 1'b0, meta_tag};
         end
         dmwbc_pkg::ACT_FILL: begin
            meta_we = 1'b1;
            meta_wa = pend_idx;
            meta_wd = {1'b1, pwr_ff, pend_tag};
            line_we = 1'b1;
            line_wa = pend_idx;
            line_wd = m_write ? m_new[LINE_W-1:0] : m_base;
         end
         default: begin
         end
      endcase
      if (cmd.clear) begin
         meta_we = 1'b1;
         meta_wa = clr_ff;
         meta_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem_ff[meta_wa] <= meta_wd;
      end
      if (cmd.capture) begin
         meta_rd_ff <= meta_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem_ff[line_wa] <= line_wd;
      end
      if (cmd.capture) begin
         line_rd_ff <= line_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      case (cmd.act)
         dmwbc_pkg::ACT_LINE_REQ: pend_in = 1'b1;
         dmwbc_pkg::ACT_FILL:     pend_in = 1'b0;
         dmwbc_pkg::ACT_FILL_ERR: pend_in = 1'b0;
         default:                 pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == dmwbc_pkg::ACT_LINE_REQ) begin
         pwr_ff    <= req_write;
         paddr_ff  <= addr_ff;
         plen_ff   <= len_ff;
         pwdata_ff <= wdata_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = dmwbc_pkg::KIND_CPU;
      stat_in      = dmwbc_pkg::STAT_OK;
      rdata_in     = '0;
      hit_in       = 1'b0;
      maddr_in     = '0;
      mdata_in     = '0;
      last_in      = 1'b1;
      case (cmd.act)
         dmwbc_pkg::ACT_BUSY: begin
            stat_in = dmwbc_pkg::STAT_BUSY;
         end
         dmwbc_pkg::ACT_LEN_ERR: begin
            stat_in = dmwbc_pkg::STAT_LEN_ERR;
         end
         dmwbc_pkg::ACT_HIT: begin
            rdata_in = serve_rd;
            hit_in   = 1'b1;
         end
         dmwbc_pkg::ACT_WB: begin
            kind_in  = dmwbc_pkg::KIND_WB;
            maddr_in = f_line_addr(meta_tag, req_idx);
            mdata_in = DW'(line_rd_ff);
            last_in  = 1'b0;
         end
         dmwbc_pkg::ACT_LINE_REQ: begin
            kind_in  = dmwbc_pkg::KIND_LINE_REQ;
            maddr_in = f_line_addr(req_tag, req_idx);
         end
         dmwbc_pkg::ACT_FILL_ERR: begin
            stat_in = dmwbc_pkg::STAT_FILL_ERR;
         end
         dmwbc_pkg::ACT_FILL: begin
            rdata_in = serve_rd;
         end
         default: begin
         end
      endcase
      if (cmd.act != dmwbc_pkg::ACT_NONE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act != dmwbc_pkg::ACT_NONE) begin
         kind_ff  <= kind_in;
         stat_ff  <= stat_in;
         rdata_ff <= rdata_in;
         hit_ff   <= hit_in;
         maddr_ff <= maddr_in;
         mdata_ff <= mdata_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_status      = stat_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_mem_address = maddr_ff;
   assign rsp_mem_data    = mdata_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

// ===== hdl/direct_mapped_writeback_cache_core.sv =====
// Top level of the direct-mapped write-back write-allocate cache.
//
//   channel   direction   handshake      carries
//   req_if    in          valid/ready    cpu read/write, memory line-fill response
//   rsp_if    out         valid/ready    cpu response, write-back, line-read request
//
// A request is taken in ST_IDLE and decided in ST_LOOKUP, once the tag and line
// reads are registered; every answer is registered, and no new request is taken
// until the controller is back in ST_IDLE. A miss with a dirty victim gives its
// write-back first and its line-read request from ST_LINE_REQ.
// After reset every entry of the tag store is swept clear, with req_if.ready low.
// A finished result waits in the output register; the controller holds its
// decision while that register is full and rsp_if.ready is low.
`default_nettype none

module direct_mapped_writeback_cache_core #(
   parameter int LINE_COUNT = dmwbc_pkg::LINE_COUNT_DEF,
   parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = dmwbc_pkg::ADDR_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   dmwbc_req_if.sink  req_if,
   dmwbc_rsp_if.source rsp_if
);

   dmwbc_pkg::cmd_type cmd;
   dmwbc_pkg::sts_type sts;
   logic               req_ready;

   dmwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dmwbc_dp #(
      .LINE_COUNT (LINE_COUNT),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_if.opcode),
      .req_address     (req_if.address),
      .req_length      (req_if.length),
      .req_write_data  (req_if.write_data),
      .req_fill_data   (req_if.fill_data),
      .req_fill_ok     (req_if.fill_ok),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_kind        (rsp_if.kind),
      .rsp_status      (rsp_if.status),
      .rsp_read_data   (rsp_if.read_data),
      .rsp_hit         (rsp_if.hit),
      .rsp_mem_address (rsp_if.mem_address),
      .rsp_mem_data    (rsp_if.mem_data),
      .rsp_last        (rsp_if.last)
   );

   assign req_if.ready = req_ready;

   // never load a result over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.act != dmwbc_pkg::ACT_NONE) |-> sts.out_free)
      else $error("result issued while output register blocked");

   // no new request between a write-back and its line-read request
   a_wb_then_req: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == dmwbc_pkg::ACT_WB) |=> !req_if.ready)
      else $error("request accepted between write-back and line read");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == dmwbc_pkg::ACT_HIT) |-> (sts.hit && !sts.pending && !sts.len_err))
      else $error("hit served without a clean lookup");

   a_fill_pending: assert property (@(posedge clock) disable iff (reset)
      ((cmd.act == dmwbc_pkg::ACT_FILL) || (cmd.act == dmwbc_pkg::ACT_FILL_ERR))
      |-> (sts.pending && sts.is_fill))
      else $error("fill handled with no miss outstanding");

endmodule

`default_nettype wire
